// ===== sv/mdf_pkg.sv =====
// Shared types, constants and helpers of the message deframer.
package mdf_pkg;

  // Default width of the length-mode header value
  localparam int unsigned LENGTH_BITS = 16;
  // Depth of the result queue; an item may push two results
  localparam int unsigned QDEPTH = 3;

  // Reset values of the configuration registers
  localparam logic        MODE_RST        = 1'b0;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd255;
  localparam logic [7:0]  DELIMITER_RST   = 8'd10;

  // Framing modes
  localparam logic MODE_DELIM  = 1'b0;
  localparam logic MODE_LENGTH = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    CFG_MODE        = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1,
    CFG_DELIMITER   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DELIM  = 2'd1,
    PH_HEADER = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_PREMATURE = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  // Result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [15:0] position;
    logic [15:0] total_length;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // Results of one item handed to the queue
  typedef struct packed {
    logic [1:0] num;
    out_t       r0;
    out_t       r1;
  } push_t;

  function automatic out_t mk_payload(logic [7:0] b, logic [15:0] pos);
    out_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload      = b;
    r.position     = pos;
    return r;
  endfunction

  function automatic out_t mk_end(logic [15:0] len, status_e st, logic lst);
    out_t r;
    r              = '0;
    r.kind         = KIND_END;
    r.total_length = len;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  // Queue pointer increment, wraps at the queue depth
  function automatic logic [1:0] qinc(logic [1:0] p);
    logic [1:0] n;
    n = (p == 2'(QDEPTH - 1)) ? 2'd0 : 2'(p + 2'd1);
    return n;
  endfunction

endpackage

// ===== sv/mdf_core.sv =====
// Framing state, configuration registers and per-byte result logic.
module mdf_core #(
  parameter int unsigned LengthBits = mdf_pkg::LENGTH_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          step_i,
  input  mdf_pkg::in_t  item_i,
  output mdf_pkg::push_t push_o
);

  localparam int unsigned HdrBytes = (LengthBits + 7) / 8;
  localparam int unsigned CntW     = (LengthBits > 16) ? LengthBits : 16;

  logic                  mode_q;
  logic [15:0]           max_payload_q;
  logic [7:0]            delimiter_q;

  mdf_pkg::phase_e       phase_q, phase_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [LengthBits-1:0] dlen_q, dlen_d;

  logic [15:0]           lim;
  logic [CntW-1:0]       lim_w;
  logic [CntW-1:0]       dlen_w;
  logic [15:0]           inc16;
  logic [CntW-1:0]       cnt_inc;
  logic [LengthBits-1:0] hdr_base;
  logic [CntW-1:0]       hdr_cnt;
  logic [LengthBits+7:0] hdr_cat;
  logic [LengthBits-1:0] hdr_len;
  logic                  mode_chg;
  mdf_pkg::push_t        push;

  // A zero limit behaves as one
  assign lim     = (max_payload_q == 16'd0) ? 16'd1 : max_payload_q;
  assign lim_w   = CntW'(lim);
  assign dlen_w  = CntW'(dlen_q);
  assign inc16   = 16'(cnt_q[15:0] + 16'd1);
  assign cnt_inc = CntW'(cnt_q + CntW'(1));

  // Header accumulation, big-endian
  assign hdr_base = (phase_q == mdf_pkg::PH_IDLE) ? '0 : dlen_q;
  assign hdr_cnt  = (phase_q == mdf_pkg::PH_IDLE) ? '0 : cnt_q;
  assign hdr_cat  = {hdr_base, item_i.data_byte};
  assign hdr_len  = hdr_cat[LengthBits-1:0];

  assign mode_chg = cfg_we_i && (cfg_idx_i == mdf_pkg::CFG_MODE) && (cfg_data_i[0] != mode_q);

  // Next state and results of one byte
  always_comb begin
    push    = '0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dlen_d  = dlen_q;
    if (item_i.stream_end) begin
      push.num = 2'd1;
      unique case (phase_q)
        mdf_pkg::PH_IDLE:   push.r0 = mdf_pkg::mk_end(16'd0, mdf_pkg::ST_NONE, 1'b0);
        mdf_pkg::PH_DELIM:  push.r0 = mdf_pkg::mk_end(cnt_q[15:0], mdf_pkg::ST_PREMATURE, 1'b1);
        mdf_pkg::PH_HEADER: push.r0 = mdf_pkg::mk_end(16'd0, mdf_pkg::ST_PREMATURE, 1'b1);
        mdf_pkg::PH_BODY:   push.r0 = mdf_pkg::mk_end(16'(dlen_w), mdf_pkg::ST_PREMATURE, 1'b1);
        default:            push.r0 = '0;
      endcase
      phase_d = mdf_pkg::PH_IDLE;
      cnt_d   = '0;
      dlen_d  = '0;
    end else if (mode_q == mdf_pkg::MODE_DELIM) begin
      push.num = 2'd1;
      if (item_i.data_byte == delimiter_q) begin
        push.r0 = mdf_pkg::mk_end(cnt_q[15:0], mdf_pkg::ST_OK, 1'b1);
        phase_d = mdf_pkg::PH_IDLE;
        cnt_d   = '0;
        dlen_d  = '0;
      end else begin
        push.r0 = mdf_pkg::mk_payload(item_i.data_byte, cnt_q[15:0]);
        phase_d = mdf_pkg::PH_DELIM;
        cnt_d   = CntW'(inc16);
        // Kept count reached the limit: close as truncated
        if (inc16 >= lim) begin
          push.num = 2'd2;
          push.r1  = mdf_pkg::mk_end(inc16, mdf_pkg::ST_TRUNC, 1'b1);
          phase_d  = mdf_pkg::PH_IDLE;
          cnt_d    = '0;
          dlen_d   = '0;
        end
      end
    end else if (phase_q == mdf_pkg::PH_IDLE || phase_q == mdf_pkg::PH_HEADER) begin
      if (CntW'(hdr_cnt + CntW'(1)) < CntW'(HdrBytes)) begin
        phase_d = mdf_pkg::PH_HEADER;
        cnt_d   = CntW'(hdr_cnt + CntW'(1));
        dlen_d  = hdr_len;
      end else if (hdr_len == '0) begin
        // Empty message ends right after its header
        push.num = 2'd1;
        push.r0  = mdf_pkg::mk_end(16'd0, mdf_pkg::ST_OK, 1'b1);
        phase_d  = mdf_pkg::PH_IDLE;
        cnt_d    = '0;
        dlen_d   = '0;
      end else begin
        phase_d = mdf_pkg::PH_BODY;
        cnt_d   = '0;
        dlen_d  = hdr_len;
      end
    end else begin
      // Length-mode body: pass up to the limit, drop the rest
      if (cnt_q < lim_w) begin
        push.num = 2'd1;
        push.r0  = mdf_pkg::mk_payload(item_i.data_byte, cnt_q[15:0]);
      end
      cnt_d = cnt_inc;
      if (cnt_inc >= dlen_w) begin
        if (cnt_q < lim_w) begin
          push.num = 2'd2;
          push.r1  = mdf_pkg::mk_end(16'(dlen_w),
                       (dlen_w > lim_w) ? mdf_pkg::ST_TRUNC : mdf_pkg::ST_OK, 1'b1);
        end else begin
          push.num = 2'd1;
          push.r0  = mdf_pkg::mk_end(16'(dlen_w),
                       (dlen_w > lim_w) ? mdf_pkg::ST_TRUNC : mdf_pkg::ST_OK, 1'b1);
        end
        phase_d = mdf_pkg::PH_IDLE;
        cnt_d   = '0;
        dlen_d  = '0;
      end
    end
    if (!step_i) begin
      push.num = 2'd0;
    end
  end

  assign push_o = push;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= mdf_pkg::MODE_RST;
      max_payload_q <= mdf_pkg::MAX_PAYLOAD_RST;
      delimiter_q   <= mdf_pkg::DELIMITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mdf_pkg::CFG_MODE:        mode_q        <= cfg_data_i[0];
        mdf_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        mdf_pkg::CFG_DELIMITER:   delimiter_q   <= cfg_data_i[7:0];
        default:                  ;
      endcase
    end
  end

  // Framing state; a mode change drops any partial message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mdf_pkg::PH_IDLE;
      cnt_q   <= '0;
      dlen_q  <= '0;
    end else if (mode_chg) begin
      phase_q <= mdf_pkg::PH_IDLE;
      cnt_q   <= '0;
      dlen_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      dlen_q  <= dlen_d;
    end
  end

  // Delimiter mode never uses the header or body phases
  a_delim_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == mdf_pkg::MODE_DELIM |->
      (phase_q == mdf_pkg::PH_IDLE || phase_q == mdf_pkg::PH_DELIM))
    else $error("delimiter mode in a length-mode phase");

  // A second result is always the closing end report
  a_second_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> (push_o.r1.kind == mdf_pkg::KIND_END && push_o.r1.last))
    else $error("second result is not a closing end report");

  // Mode change returns the framer to idle
  a_mode_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_chg |=> (phase_q == mdf_pkg::PH_IDLE && cnt_q == '0))
    else $error("mode change left a partial message");

endmodule

// ===== sv/mdf_outq.sv =====
// Three-entry result queue; takes up to two results per cycle, gives one per cycle while out_stall_i is low.
module mdf_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mdf_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mdf_pkg::out_t  out_data_o
);

  mdf_pkg::out_t ent_q [mdf_pkg::QDEPTH];
  logic [1:0]    wr_q, rd_q, cnt_q;
  logic [1:0]    wr_d, rd_d, cnt_d;
  logic          pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[rd_q];
  // Room for a worst-case item of two results
  assign room_o      = (cnt_q <= 2'd1);

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = pop ? mdf_pkg::qinc(rd_q) : rd_q;
    unique case (push_i.num)
      2'd1:    wr_d = mdf_pkg::qinc(wr_q);
      2'd2:    wr_d = mdf_pkg::qinc(mdf_pkg::qinc(wr_q));
      default: wr_d = wr_q;
    endcase
    cnt_d = 2'(cnt_q + push_i.num - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      ent_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      ent_q[mdf_pkg::qinc(wr_q)] <= push_i.r1;
    end
  end

  // Results only arrive when the queue can hold two more
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> cnt_q <= 2'd1)
    else $error("result queue overflow");

  // A two-result transfer with no pop raises the count by two
  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2 && !pop) |=> cnt_q == 2'($past(cnt_q) + 2'd2))
    else $error("double push lost an entry");

endmodule

// ===== sv/message_deframer.sv =====
// Top level of the message deframer: input register, framer core, result queue.
//
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  input    | in_valid_i, in_stall_o, in_data_i | in
//  output   | out_valid_o, out_stall_i, out_data_o | out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i   | in
//
// One byte per cycle while the input does not stall: a transfer lands in the input
// register, is framed when the queue has room and its results (up to two) enter a
// three-entry result queue. Results leave at one per cycle while out_stall_i is
// low; the input stalls when a byte waits in the input register and the queue
// holds two or more.
// Reset restores mode 0, limit 255, delimiter newline and an idle framer.
module message_deframer #(
  parameter int unsigned LengthBits = mdf_pkg::LENGTH_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mdf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mdf_pkg::out_t out_data_o
);

  logic           in_vld_q;
  mdf_pkg::in_t   in_q;
  logic           room;
  logic           step;
  mdf_pkg::push_t push;

  // Registered byte moves on when the queue has room
  assign step       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  mdf_core #(
    .LengthBits(LengthBits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (in_q),
    .push_o     (push)
  );

  mdf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
